### rtl/kf2_pkg.sv
// Shared widths, register map, reset values and types of the two-axis Kalman filter.
package kf2_pkg;

  localparam int LAT_WIDTH = 31;
  localparam int LON_WIDTH = 32;
  localparam int CFG_WIDTH = 32;
  localparam int ADDR_WIDTH = 3;
  localparam int IDX_WIDTH = 1;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int VAR_FRAC_BITS_DEF = 30;

  localparam logic [IDX_WIDTH-1:0] REG_PROC_NOISE = 1'd0;
  localparam logic [IDX_WIDTH-1:0] REG_MEAS_NOISE = 1'd1;

  localparam logic [CFG_WIDTH-1:0] PROC_NOISE_RST = 32'd10737418;
  localparam logic [CFG_WIDTH-1:0] MEAS_NOISE_RST = 32'd107374182;

  localparam longint LAT_LIMIT = 64'sd900000000;
  localparam longint LON_LIMIT = 64'sd1800000000;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] proc_noise;
    logic [CFG_WIDTH-1:0] meas_noise;
  } kf2_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DEN,
    ST_DIV,
    ST_ROUND,
    ST_UPDATE
  } kf2_state_t;

endpackage

### rtl/kf2_ifs.sv
// Valid/ready channel interfaces for measurements and estimates.
interface kf2_meas_if;
  import kf2_pkg::*;
  logic valid;
  logic ready;
  logic signed [LAT_WIDTH-1:0] meas_lat;
  logic signed [LON_WIDTH-1:0] meas_lon;
  modport source (output valid, meas_lat, meas_lon, input ready);
  modport sink (input valid, meas_lat, meas_lon, output ready);
endinterface

interface kf2_est_if;
  import kf2_pkg::*;
  logic valid;
  logic ready;
  logic signed [LAT_WIDTH-1:0] est_lat;
  logic signed [LON_WIDTH-1:0] est_lon;
  modport source (output valid, est_lat, est_lon, input ready);
  modport sink (input valid, est_lat, est_lon, output ready);
endinterface

### rtl/kf2_regs.sv
// APB register file holding the process and measurement noise variances.
module kf2_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kf2_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [kf2_pkg::CFG_WIDTH-1:0]   pwdata,
  output logic [kf2_pkg::CFG_WIDTH-1:0]   prdata,
  output logic                            pready,
  output kf2_pkg::kf2_cfg_t               cfg
);
  import kf2_pkg::*;

  logic [IDX_WIDTH-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_WIDTH-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.proc_noise <= PROC_NOISE_RST;
      cfg.meas_noise <= MEAS_NOISE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROC_NOISE: cfg.proc_noise <= pwdata;
        REG_MEAS_NOISE: cfg.meas_noise <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROC_NOISE: prdata = cfg.proc_noise;
      REG_MEAS_NOISE: prdata = cfg.meas_noise;
    endcase
  end

endmodule

### rtl/two_axis_scalar_kalman_filter.sv
// Two-axis scalar Kalman filter with a bit-serial gain divider and shift-add multipliers.
//
//  channel | dir | handshake              | payload
//  meas    | in  | valid/ready            | meas_lat (s31), meas_lon (s32)
//  est     | out | valid/ready            | est_lat (s31), est_lon (s32)
//  apb     | in  | psel/penable, pready=1 | q at 0x0, r at 0x4 (32 bit each)
//
// One measurement passes PREP, DEN, DIV, ROUND and UPDATE between accepts: the
// restoring divider retires one gain bit per cycle, and the three shift-add
// multipliers consume each gain bit in the same cycle it appears.
// Reset (rst, synchronous) sets the variance to 1.0, both estimates to zero.
// A result waits in the output register; the filter stalls in its last step
// until that register is free, and takes a new measurement only when idle.
module two_axis_scalar_kalman_filter #(
  parameter int COORD_WIDTH   = kf2_pkg::COORD_WIDTH_DEF,
  parameter int VAR_FRAC_BITS = kf2_pkg::VAR_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  kf2_meas_if.sink                        meas,
  kf2_est_if.source                       est,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kf2_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [kf2_pkg::CFG_WIDTH-1:0]   pwdata,
  output logic [kf2_pkg::CFG_WIDTH-1:0]   prdata,
  output logic                            pready
);
  import kf2_pkg::*;

  localparam int F     = VAR_FRAC_BITS;
  localparam int CW    = COORD_WIDTH;
  localparam int PW    = F + 4;
  localparam int ZW    = (CW > LON_WIDTH) ? CW : LON_WIDTH;
  localparam int MW    = ZW + 1;
  localparam int AW    = F + MW;
  localparam int PAW   = F + PW;
  localparam int SW    = ((PW > CFG_WIDTH) ? PW : CFG_WIDTH) + 1;
  localparam int DNW   = SW + 1;
  localparam int CNT_W = $clog2(F);

  localparam longint unsigned EPS_RAW = ((64'd1 << F) + 64'd50000000) / 64'd100000000;
  localparam longint unsigned EPS     = (EPS_RAW == 64'd0) ? 64'd1 : EPS_RAW;
  localparam longint unsigned HALF    = 64'd1 << (F - 1);
  localparam longint CW_MAX  = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint LAT_LIM = (LAT_LIMIT < CW_MAX) ? LAT_LIMIT : CW_MAX;
  localparam longint LON_LIM = (LON_LIMIT < CW_MAX) ? LON_LIMIT : CW_MAX;

  localparam logic signed [MW:0] LAT_HI = (MW+1)'(LAT_LIM);
  localparam logic signed [MW:0] LAT_LO = -LAT_HI;
  localparam logic signed [MW:0] LON_HI = (MW+1)'(LON_LIM);
  localparam logic signed [MW:0] LON_LO = -LON_HI;
  localparam logic [SW-1:0] VAR_MAX = {{(SW-PW){1'b0}}, {PW{1'b1}}};
  localparam logic [PW-1:0] VAR_ONE = PW'(64'd1 << F);

  kf2_cfg_t cfg;

  kf2_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kf2_state_t state, state_next;

  // filter state
  logic [PW-1:0]        p;
  logic signed [CW-1:0] x_lat;
  logic signed [CW-1:0] x_lon;

  // per-item working registers
  logic signed [LAT_WIDTH-1:0] z_lat;
  logic signed [LON_WIDTH-1:0] z_lon;
  logic [PW-1:0]   pp;
  logic [MW-1:0]   mag_lat, mag_lon;
  logic            neg_lat, neg_lon;
  logic [DNW-1:0]  den, rem;
  logic [AW-1:0]   acc_lat, acc_lon;
  logic [PAW-1:0]  acc_p;
  logic [MW-1:0]   delta_lat, delta_lon;
  logic [CNT_W-1:0] cnt;

  logic                       out_valid;
  logic signed [LAT_WIDTH-1:0] out_lat;
  logic signed [LON_WIDTH-1:0] out_lon;

  // control
  logic accept, upd_go;

  // combinational datapath
  logic [SW-1:0]        sum_pq;
  logic signed [MW-1:0] d_lat, d_lon;
  logic [DNW:0]         rem2;
  logic                 qbit;
  logic [AW:0]          rnd_lat, rnd_lon;
  logic [PAW:0]         rnd_p;
  logic signed [MW:0]   xs_lat, xs_lon, nx_lat, nx_lon, cl_lat, cl_lon;

  function automatic logic signed [MW:0] clamp(input logic signed [MW:0] v,
                                               input logic signed [MW:0] hi,
                                               input logic signed [MW:0] lo);
    logic signed [MW:0] r;
    r = v;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    return r;
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (meas.valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DEN;
      ST_DEN:    state_next = ST_DIV;
      ST_DIV:    if (cnt == '0) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_UPDATE;
      ST_UPDATE: if (!out_valid || est.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    meas.ready = (state == ST_IDLE);
    accept     = (state == ST_IDLE) && meas.valid;
    upd_go     = (state == ST_UPDATE) && (!out_valid || est.ready);
  end

  assign est.valid   = out_valid;
  assign est.est_lat = out_lat;
  assign est.est_lon = out_lon;

  always_comb begin
    sum_pq = {{(SW-PW){1'b0}}, p} + {{(SW-CFG_WIDTH){1'b0}}, cfg.proc_noise};
    d_lat  = {{(MW-LAT_WIDTH){z_lat[LAT_WIDTH-1]}}, z_lat}
           - {{(MW-CW){x_lat[CW-1]}}, x_lat};
    d_lon  = {{(MW-LON_WIDTH){z_lon[LON_WIDTH-1]}}, z_lon}
           - {{(MW-CW){x_lon[CW-1]}}, x_lon};
    rem2   = {rem, 1'b0};
    qbit   = (rem2 >= {1'b0, den});
    rnd_lat = {1'b0, acc_lat} + (AW+1)'(HALF);
    rnd_lon = {1'b0, acc_lon} + (AW+1)'(HALF);
    rnd_p   = {1'b0, pp, {F{1'b0}}} - {1'b0, acc_p} + (PAW+1)'(HALF);
    xs_lat = {{(MW+1-CW){x_lat[CW-1]}}, x_lat};
    xs_lon = {{(MW+1-CW){x_lon[CW-1]}}, x_lon};
    nx_lat = neg_lat ? xs_lat - $signed({1'b0, delta_lat}) : xs_lat + $signed({1'b0, delta_lat});
    nx_lon = neg_lon ? xs_lon - $signed({1'b0, delta_lon}) : xs_lon + $signed({1'b0, delta_lon});
    cl_lat = clamp(nx_lat, LAT_HI, LAT_LO);
    cl_lon = clamp(nx_lon, LON_HI, LON_LO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      p         <= VAR_ONE;
      x_lat     <= '0;
      x_lon     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ROUND) p <= rnd_p[F+PW-1:F];
      if (upd_go) begin
        x_lat     <= cl_lat[CW-1:0];
        x_lon     <= cl_lon[CW-1:0];
        out_valid <= 1'b1;
      end else if (est.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z_lat <= meas.meas_lat;
      z_lon <= meas.meas_lon;
    end
    unique case (state)
      ST_PREP: begin
        pp      <= (sum_pq > VAR_MAX) ? VAR_MAX[PW-1:0] : sum_pq[PW-1:0];
        neg_lat <= d_lat[MW-1];
        neg_lon <= d_lon[MW-1];
        mag_lat <= d_lat[MW-1] ? MW'(-d_lat) : MW'(d_lat);
        mag_lon <= d_lon[MW-1] ? MW'(-d_lon) : MW'(d_lon);
      end
      ST_DEN: begin
        den     <= {{(DNW-PW){1'b0}}, pp} + {{(DNW-CFG_WIDTH){1'b0}}, cfg.meas_noise}
                 + DNW'(EPS);
        rem     <= {{(DNW-PW){1'b0}}, pp};
        acc_lat <= '0;
        acc_lon <= '0;
        acc_p   <= '0;
        cnt     <= CNT_W'(F - 1);
      end
      ST_DIV: begin
        // one quotient bit per cycle, fed straight into the three multipliers
        rem     <= qbit ? rem2[DNW-1:0] - den : rem2[DNW-1:0];
        acc_lat <= {acc_lat[AW-2:0], 1'b0} + (qbit ? {{F{1'b0}}, mag_lat} : '0);
        acc_lon <= {acc_lon[AW-2:0], 1'b0} + (qbit ? {{F{1'b0}}, mag_lon} : '0);
        acc_p   <= {acc_p[PAW-2:0], 1'b0} + (qbit ? {{F{1'b0}}, pp} : '0);
        cnt     <= cnt - 1'b1;
      end
      ST_ROUND: begin
        delta_lat <= rnd_lat[F+MW-1:F];
        delta_lon <= rnd_lon[F+MW-1:F];
      end
      default: ;
    endcase
    if (upd_go) begin
      out_lat <= cl_lat[LAT_WIDTH-1:0];
      out_lon <= cl_lon[LON_WIDTH-1:0];
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < den))
    else $error("divider remainder reached the denominator");

  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |=> (p <= pp))
    else $error("updated variance exceeds predicted variance");

  a_est_in_range: assert property (@(posedge clk) disable iff (rst)
    (xs_lat <= LAT_HI) && (xs_lat >= LAT_LO) && (xs_lon <= LON_HI) && (xs_lon >= LON_LO))
    else $error("estimate outside coordinate range");

  a_update_delivers: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> (out_valid && (state == ST_IDLE)))
    else $error("update did not produce a result");

endmodule
